>>> rtl/bounded_deque_drop_on_full_defines.svh
// ----------------------------------------------------------------------------
// Bounded deque assertion macros
// Shared concurrent assertion forms, clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_DROP_ON_FULL_DEFINES_SVH
`define BOUNDED_DEQUE_DROP_ON_FULL_DEFINES_SVH

// Same-cycle implication.
`define BDQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BDQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// Bounded deque package
// Widths, operation codes and the result flag group shared by all modules.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = 7;
  localparam int OP_W      = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_e;

  typedef struct packed {
    logic             evicted;
    logic             was_empty;
    logic [CNT_W-1:0] fill_count;
  } res_t;

endpackage

>>> rtl/bounded_deque_drop_on_full.sv
// ----------------------------------------------------------------------------
// Bounded deque with drop on full
// Ring-buffer double-ended queue of signed words with a set capacity.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one operation per beat: tuser is the op code
//   (push back, push front, pop front, pop back), tdata the word to push.
//   Master stream returns one result beat per operation: tdata holds the
//   popped word and the fill count after the operation, tuser the empty and
//   evicted flags. A push on a full queue drops the front entry (push back)
//   or the back entry (push front) and sets evicted. A pop on an empty queue
//   returns zero with was_empty set and leaves the queue as it was.
//   Pushes and empty pops give their result in the cycle after the beat; a
//   pop that reads the single-port entry RAM gives it through the RAM read
//   register and then the result register. Pushes sustain one beat per cycle
//   while results are taken and no cfg beat waits; pops stall until the read lands.
//   The cfg channel writes the capacity (0 acts as 1, values above the depth
//   act as the depth); a lower capacity trims entries off the back.
//   Reset empties the queue and sets capacity 64; RAM contents are not cleared.
//   A stalled master holds its result register; the slave side takes a new
//   beat in the cycle the result is taken.
// ----------------------------------------------------------------------------
`include "bounded_deque_drop_on_full_defines.svh"

module bounded_deque_drop_on_full import bdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write: capacity
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CNT_W-1:0]      cfg_data_i,
  // operation beats
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [DATA_W-1:0]     s_axis_tdata,  // [31:0] push_value
  input  logic [OP_W-1:0]       s_axis_tuser,  // [1:0] op
  // result beats
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [39:0]           m_axis_tdata,  // [31:0] popped_value, [38:32] fill_count
  output logic [1:0]            m_axis_tuser   // [0] was_empty, [1] evicted
);

  localparam int AW = $clog2(DEPTH);

  logic              in_accept;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_addr;
  logic [DATA_W-1:0] mem_rdata;
  res_t              res;

  logic              rd_pending_q;
  res_t              pend_res_q;
  logic              out_valid_q;
  res_t              out_res_q;
  logic [DATA_W-1:0] out_data_q;

  // Take a beat when no RAM read is in flight, no cfg beat is offered and the
  // result slot frees up.
  assign s_axis_tready = !rd_pending_q && !cfg_valid_i && (!out_valid_q || m_axis_tready);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  bdq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_cap_i  (cfg_data_i),
    .op_valid_i (in_accept),
    .op_i       (op_e'(s_axis_tuser)),
    .mem_we_o   (mem_we),
    .mem_re_o   (mem_re),
    .mem_addr_o (mem_addr),
    .res_o      (res)
  );

  bdq_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (s_axis_tdata),
    .rdata_o (mem_rdata)
  );

  // Result slot: loaded at accept for pushes and empty pops, or in the cycle
  // after from the RAM for real pops.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pending_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else if (rd_pending_q) begin
      rd_pending_q <= 1'b0;
      out_valid_q  <= 1'b1;
    end else if (in_accept) begin
      rd_pending_q <= mem_re;
      out_valid_q  <= !mem_re;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pending_q) begin
      out_data_q <= mem_rdata;
      out_res_q  <= pend_res_q;
    end else if (in_accept) begin
      pend_res_q <= res;
      if (!mem_re) begin
        out_data_q <= '0;
        out_res_q  <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_res_q.fill_count, out_data_q};
  assign m_axis_tuser  = {out_res_q.evicted, out_res_q.was_empty};

  // A RAM read only lands in a free result slot.
  `BDQ_ASSERT_IMP(a_pend_slot_free, rd_pending_q, !out_valid_q, "read lands on full slot")
  // A pop that reads the RAM delivers through the pending stage.
  `BDQ_ASSERT_NXT(a_read_pends, in_accept && mem_re, rd_pending_q, "pop read not pending")
  // An empty pop reports zero.
  `BDQ_ASSERT_IMP(a_empty_zero, out_valid_q && out_res_q.was_empty,
                  out_data_q == '0, "empty pop returned data")

endmodule

>>> rtl/bdq_mem.sv
// ----------------------------------------------------------------------------
// Bounded deque entry store
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module bdq_mem import bdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [AW-1:0]     addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded deque pointer control
// Holds head, count and capacity; turns one operation into at most one RAM access.
// ----------------------------------------------------------------------------
module bdq_ctrl import bdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_cap_i,
  input  logic             op_valid_i,
  input  op_e              op_i,
  output logic             mem_we_o,
  output logic             mem_re_o,
  output logic [AW-1:0]    mem_addr_o,
  output res_t             res_o
);

  localparam int SW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'((DEPTH > CNT_MAX) ? CNT_MAX : DEPTH);
  localparam logic [SW-1:0]    DEPTH_S = SW'(DEPTH);
  localparam logic [AW-1:0]    LAST_IX = AW'(DEPTH - 1);

  logic [CNT_W-1:0] cap_q;
  logic [AW-1:0]    head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] eff_cap, cfg_eff;
  logic             full, empty;
  logic [AW-1:0]    head_inc, head_dec, back_ix, tail_ix;

  function automatic logic [CNT_W-1:0] clamp_cap(input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] r;
    if (cap == '0) begin
      r = CNT_W'(1);
    end else if (32'(cap) > DEPTH) begin
      r = DEPTH_C;
    end else begin
      r = cap;
    end
    return r;
  endfunction

  // Sum stays below twice the depth: one compare and subtract.
  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    logic [AW-1:0] r;
    if (s >= DEPTH_S) begin
      r = AW'(s - DEPTH_S);
    end else begin
      r = AW'(s);
    end
    return r;
  endfunction

  assign eff_cap  = clamp_cap(cap_q);
  assign cfg_eff  = clamp_cap(cfg_cap_i);
  assign full     = count_q >= eff_cap;
  assign empty    = count_q == '0;
  assign head_inc = wrap(SW'(head_q) + SW'(1));
  assign head_dec = (head_q == '0) ? LAST_IX : head_q - AW'(1);
  assign tail_ix  = wrap(SW'(head_q) + SW'(count_q));
  assign back_ix  = wrap(SW'(head_q) + SW'(count_q) - SW'(1));

  always_comb begin
    head_d          = head_q;
    count_d         = count_q;
    mem_we_o        = 1'b0;
    mem_re_o        = 1'b0;
    mem_addr_o      = head_q;
    res_o.evicted   = 1'b0;
    res_o.was_empty = 1'b0;
    case (op_i)
      OP_PUSH_BACK: begin
        mem_we_o   = op_valid_i;
        mem_addr_o = tail_ix;
        if (full) begin
          head_d        = head_inc;
          res_o.evicted = 1'b1;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_PUSH_FRONT: begin
        mem_we_o   = op_valid_i;
        mem_addr_o = head_dec;
        head_d     = head_dec;
        if (full) begin
          res_o.evicted = 1'b1;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          res_o.was_empty = 1'b1;
        end else begin
          mem_re_o = op_valid_i;
          head_d   = head_inc;
          count_d  = count_q - CNT_W'(1);
        end
      end
      default: begin
        mem_addr_o = back_ix;
        if (empty) begin
          res_o.was_empty = 1'b1;
        end else begin
          mem_re_o = op_valid_i;
          count_d  = count_q - CNT_W'(1);
        end
      end
    endcase
    res_o.fill_count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      head_q  <= '0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      cap_q <= cfg_cap_i;
      if (count_q > cfg_eff) begin
        count_q <= cfg_eff;
      end
    end else if (op_valid_i) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

endmodule
